>>> rtl/lzo_pkg.sv
// lzo_pkg: shared types and constants of the layer z-order manager
// used by every rtl file of the block except lzo_ram; depends on nothing
package lzo_pkg;

	localparam int ID_W  = 8;
	localparam int REQ_W = 10;
	localparam int HGT_W = 9;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;

	typedef struct packed {
		logic idle;
		logic load;
		logic plan;
		logic shift;
		logic place;
		logic scan;
		logic finish;
	} lzo_cmd_t;

	typedef struct packed {
		logic req_valid;
		logic alloc;
		logic changed;
		logic shift;
		logic last;
		logic hit;
		logic scan_end;
		logic out_free;
	} lzo_sts_t;

endpackage

>>> rtl/lzo_if.sv
// lzo_if: request and response channels of the layer z-order manager
// valid/ready handshake with payload; depends on lzo_pkg
interface lzo_req_if import lzo_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [1:0]              opcode;
	logic [ID_W-1:0]         layer_id;
	logic signed [REQ_W-1:0] requested_height;

	modport source (output valid, opcode, layer_id, requested_height, input ready);
	modport sink (input valid, opcode, layer_id, requested_height, output ready);
endinterface

interface lzo_rsp_if import lzo_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic                    status;
	logic [ID_W-1:0]         result_layer;
	logic signed [HGT_W-1:0] final_height;
	logic signed [HGT_W-1:0] top_height;
	logic                    refresh_needed;

	modport source (output valid, status, result_layer, final_height, top_height,
		refresh_needed, input ready);
	modport sink (input valid, status, result_layer, final_height, top_height,
		refresh_needed, output ready);
endinterface

>>> rtl/lzo_ram.sv
// lzo_ram: generic single write, single read ram with registered read
// no dependencies
module lzo_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/lzo_ctrl.sv
// lzo_ctrl: sequencer of the layer z-order manager
// one-hot state machine; drives lzo_dp through command/status structs from lzo_pkg
module lzo_ctrl import lzo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  lzo_sts_t sts,
	output lzo_cmd_t cmd
);
	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_READ   = 9'b000000010,
		S_PLAN   = 9'b000000100,
		S_BRANCH = 9'b000001000,
		S_SCAN   = 9'b000010000,
		S_SHIFT  = 9'b000100000,
		S_DRAIN  = 9'b001000000,
		S_PLACE  = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		cmd        = '0;
		state_n    = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				cmd.load = sts.req_valid;
				if (sts.req_valid) state_n = S_READ;
			end
			S_READ: state_n = S_PLAN;
			S_PLAN: begin
				cmd.plan = 1'b1;
				state_n  = S_BRANCH;
			end
			S_BRANCH: begin
				if (sts.alloc) state_n = S_SCAN;
				else if (sts.changed && sts.shift) state_n = S_SHIFT;
				else if (sts.changed) state_n = S_PLACE;
				else state_n = S_DONE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.scan_end) state_n = S_DONE;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.last) state_n = S_DRAIN;
			end
			S_DRAIN: state_n = S_PLACE;
			S_PLACE: begin
				cmd.place = 1'b1;
				state_n   = S_DONE;
			end
			S_DONE: begin
				cmd.finish = sts.out_free;
				if (sts.out_free) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end
endmodule

>>> rtl/lzo_dp.sv
// lzo_dp: datapath of the layer z-order manager: slot flags, height and order rams
// depends on lzo_pkg, lzo_if and lzo_ram; sequenced by lzo_ctrl
module lzo_dp import lzo_pkg::*; #(
	parameter int LAYER_SLOTS = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	lzo_req_if.sink  req,
	lzo_rsp_if.source rsp,
	input  lzo_cmd_t cmd,
	output lzo_sts_t sts
);
	localparam int AW = $clog2(LAYER_SLOTS);
	localparam int CW = AW + 1;
	localparam logic signed [REQ_W-1:0] NEG1 = -10'sd1;
	localparam logic signed [REQ_W-1:0] HMAX = REQ_W'(LAYER_SLOTS - 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(LAYER_SLOTS - 1);

	logic [LAYER_SLOTS-1:0]  used_q;
	logic [1:0]              op_q;
	logic [ID_W-1:0]         id_q;
	logic signed [REQ_W-1:0] req_q;
	logic signed [HGT_W-1:0] top_q;
	logic signed [REQ_W-1:0] h_q;
	logic signed [REQ_W-1:0] dst_q;
	logic signed [REQ_W-1:0] dst_s1;
	logic                    wr_s1;
	logic [CW-1:0]           n_q;
	logic                    up_q;
	logic                    hide_q;
	logic                    grow_q;
	logic                    chg_q;
	logic                    free_q;
	logic signed [HGT_W-1:0] fh_q;
	logic                    status_q;
	logic [ID_W-1:0]         res_q;
	logic [AW-1:0]           scan_q;
	logic                    out_valid_q;

	logic [HGT_W-1:0]        hgt_rd;
	logic [ID_W-1:0]         ord_rd;
	logic                    hgt_we, ord_we;
	logic [AW-1:0]           hgt_waddr, ord_waddr, ord_raddr;
	logic [HGT_W-1:0]        hgt_wdata;
	logic [ID_W-1:0]         ord_wdata;

	logic                    in_rng, used_id, act_set, act_free, changed, scan_hit;
	logic signed [REQ_W-1:0] old, top10, limit0, limit, hreq, hc, h, src;
	logic signed [REQ_W-1:0] dst_n, n_n, fh_n;
	logic                    up_n;

	assign in_rng   = {1'b0, id_q} < (ID_W + 1)'(LAYER_SLOTS);
	assign used_id  = in_rng && used_q[id_q[AW-1:0]];
	assign old      = used_id ? {hgt_rd[HGT_W-1], hgt_rd} : NEG1;
	assign top10    = {top_q[HGT_W-1], top_q};
	assign limit0   = (old >= 0) ? top10 : top10 + 10'sd1;
	assign limit    = (limit0 > HMAX) ? HMAX : limit0;
	assign hreq     = (req_q > limit) ? limit : req_q;
	assign hc       = (hreq < NEG1) ? NEG1 : hreq;
	assign act_set  = (op_q == OP_SET) && used_id;
	assign act_free = (op_q == OP_FREE) && used_id && (old >= 0);
	assign h        = act_free ? NEG1 : hc;
	assign changed  = (act_set || act_free) && (old != h);
	assign dst_n    = (old < 0) ? top10 + 10'sd1 : old;
	assign up_n     = (old > h) ? (h < 0) : (old >= 0);
	assign scan_hit = !used_q[scan_q];
	assign src      = up_q ? dst_q + 10'sd1 : dst_q - 10'sd1;

	always_comb begin
		if (!changed) n_n = '0;
		else if (old > h) n_n = (h >= 0) ? old - h : top10 - old;
		else n_n = (old >= 0) ? h - old : top10 + 10'sd1 - h;
		if (op_q == OP_ALLOC) fh_n = NEG1;
		else if (act_set) fh_n = h;
		else if (op_q == OP_FREE && used_id) fh_n = NEG1;
		else fh_n = old;
	end

	// ram write ports, users are exclusive in time
	always_comb begin
		hgt_we    = 1'b0;
		hgt_waddr = id_q[AW-1:0];
		hgt_wdata = h_q[HGT_W-1:0];
		ord_we    = 1'b0;
		ord_waddr = h_q[AW-1:0];
		ord_wdata = id_q;
		ord_raddr = src[AW-1:0];
		if (wr_s1) begin
			hgt_we    = 1'b1;
			hgt_waddr = ord_rd[AW-1:0];
			hgt_wdata = dst_s1[HGT_W-1:0];
			ord_we    = 1'b1;
			ord_waddr = dst_s1[AW-1:0];
			ord_wdata = ord_rd;
		end else if (cmd.place) begin
			hgt_we = 1'b1;
			ord_we = !hide_q;
		end else if (cmd.scan && scan_hit) begin
			hgt_we    = 1'b1;
			hgt_waddr = scan_q;
			hgt_wdata = NEG1[HGT_W-1:0];
		end
	end

	lzo_ram #(.W(HGT_W), .D(LAYER_SLOTS)) u_hgt_ram (
		.clk   (clk),
		.we    (hgt_we),
		.waddr (hgt_waddr),
		.wdata (hgt_wdata),
		.raddr (id_q[AW-1:0]),
		.rdata (hgt_rd)
	);

	lzo_ram #(.W(ID_W), .D(LAYER_SLOTS)) u_ord_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (ord_raddr),
		.rdata (ord_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			top_q       <= -9'sd1;
			wr_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_s1 <= cmd.shift;
			if (cmd.place) begin
				if (hide_q) top_q <= top_q - 9'sd1;
				else if (grow_q) top_q <= top_q + 9'sd1;
			end
			if (cmd.scan && scan_hit) used_q[scan_q] <= 1'b1;
			if (cmd.finish && free_q) used_q[id_q[AW-1:0]] <= 1'b0;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req.opcode;
			id_q     <= req.layer_id;
			req_q    <= req.requested_height;
			scan_q   <= '0;
			status_q <= (req.opcode == OP_ALLOC);
			res_q    <= (req.opcode == OP_ALLOC) ? '0 : req.layer_id;
		end
		if (cmd.plan) begin
			h_q    <= h;
			dst_q  <= dst_n;
			n_q    <= n_n[CW-1:0];
			up_q   <= up_n;
			hide_q <= (h < 0);
			grow_q <= (old < 0);
			chg_q  <= changed;
			free_q <= (op_q == OP_FREE) && used_id;
			fh_q   <= fh_n[HGT_W-1:0];
		end
		if (cmd.shift) begin
			dst_q  <= src;
			dst_s1 <= dst_q;
			n_q    <= n_q - CW'(1);
		end
		if (cmd.scan) begin
			if (scan_hit) begin
				status_q <= 1'b0;
				res_q    <= ID_W'(scan_q);
			end else if (scan_q != LAST_SLOT) begin
				scan_q <= scan_q + AW'(1);
			end
		end
		if (cmd.finish) begin
			rsp.status         <= status_q;
			rsp.result_layer   <= res_q;
			rsp.final_height   <= fh_q;
			rsp.top_height     <= top_q;
			rsp.refresh_needed <= chg_q;
		end
	end

	assign req.ready = cmd.idle;
	assign rsp.valid = out_valid_q;

	always_comb begin
		sts           = '0;
		sts.req_valid = req.valid;
		sts.alloc     = (op_q == OP_ALLOC);
		sts.changed   = chg_q;
		sts.shift     = (n_q != '0);
		sts.last      = (n_q == CW'(1));
		sts.hit       = scan_hit;
		sts.scan_end  = (scan_q == LAST_SLOT);
		sts.out_free  = !out_valid_q || rsp.ready;
	end
endmodule

>>> rtl/layer_z_order_manager_unit.sv
// layer_z_order_manager_unit: stacking order of up to 256 display layers
// one request at a time; allocate scans slot flags one slot per cycle
// set height and free shift the order ram one entry per cycle
// a waiting response stalls the next request only in the final state of the current one
// reset: all slots free, all layers hidden, top -1; order ram is not cleared
module layer_z_order_manager_unit import lzo_pkg::*; #(
	parameter int MAX_LAYERS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	lzo_req_if.sink   req,
	lzo_rsp_if.source rsp
);
	localparam int LAYER_SLOTS = (MAX_LAYERS < 256) ? MAX_LAYERS : 256;

	lzo_cmd_t cmd;
	lzo_sts_t sts;

	lzo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	lzo_dp #(.LAYER_SLOTS(LAYER_SLOTS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule

>>> tb/lzo_tb_if.sv
`timescale 1ns / 100ps
// testbench side of the layer stack channels; the bench reuses lzo_req_if and lzo_rsp_if from rtl
// this file only holds the extra opcode name OP_NOP used by the bench; depends on lzo_pkg
package lzo_tb_pkg;
	import lzo_pkg::*;
	localparam logic [1:0] OP_NOP = 2'd3;
endpackage

>>> tb/tb.sv
`timescale 1ns / 100ps
// bench for layer_z_order_manager_unit: directed and random allocate, set height, free, nop
// requests; a behavioral stack model predicts every response; depends on lzo_pkg, lzo_tb_pkg, lzo_if
module tb;
	import lzo_pkg::*;
	import lzo_tb_pkg::*;

	typedef struct packed {
		logic                    status;
		logic [ID_W-1:0]         layer;
		logic signed [HGT_W-1:0] fh;
		logic signed [HGT_W-1:0] top;
		logic                    refresh;
	} stack_rsp_t;

	logic clk = 0;
	logic arst_n = 0;
	lzo_req_if req ();
	lzo_rsp_if rsp ();

	layer_z_order_manager_unit dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	bit              used_m [256];
	int              hgt_m [256];
	logic [7:0]      order_m [256];
	int              top_m;
	stack_rsp_t      pending_rsp [$];
	int              errors = 0;
	int              n_sent = 0;
	int              n_rsp = 0;
	int              send_idle = 0;
	int              recv_idle = 0;
	bit              hold_rsp = 0;
	longint          cycles = 0;

	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic void put_layer(input int k, input logic [7:0] id);
		order_m[k & 255] = id;
		hgt_m[id] = k;
	endfunction

	function automatic bit move_layer(input logic [7:0] id, input int want);
		int old;
		int lim;
		int h;
		int k;
		old = hgt_m[id];
		lim = (old >= 0) ? top_m : top_m + 1;
		h = want;
		if (lim > 255) lim = 255;
		if (h > lim) h = lim;
		if (h < -1) h = -1;
		if (old > h) begin
			if (h >= 0) begin
				for (k = old; k > h; k--) put_layer(k, order_m[(k - 1) & 255]);
				put_layer(h, id);
			end else begin
				for (k = old; k < top_m; k++) put_layer(k, order_m[(k + 1) & 255]);
				top_m--;
				hgt_m[id] = -1;
			end
			return 1'b1;
		end
		if (old < h) begin
			if (old >= 0) begin
				for (k = old; k < h; k++) put_layer(k, order_m[(k + 1) & 255]);
				put_layer(h, id);
			end else begin
				for (k = top_m + 1; k > h; k--) put_layer(k, order_m[(k - 1) & 255]);
				put_layer(h, id);
				top_m++;
			end
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic stack_rsp_t predict_stack(input logic [1:0] op, input logic [7:0] id,
			input logic signed [9:0] want);
		stack_rsp_t r;
		bit ok;
		r = '0;
		r.layer = id;
		ok = used_m[id];
		if (op == OP_ALLOC) begin
			r.status = 1'b1;
			r.layer = '0;
			for (int i = 0; i < 256; i++) begin
				if (!used_m[i]) begin
					used_m[i] = 1;
					hgt_m[i] = -1;
					r.status = 1'b0;
					r.layer = i[7:0];
					break;
				end
			end
			r.fh = -9'sd1;
		end else if (op == OP_SET && ok) begin
			r.refresh = move_layer(id, int'(want));
			r.fh = HGT_W'(hgt_m[id]);
		end else if (op == OP_FREE && ok) begin
			if (hgt_m[id] >= 0) r.refresh = move_layer(id, -1);
			used_m[id] = 0;
			r.fh = HGT_W'(hgt_m[id]);
		end else begin
			r.fh = HGT_W'(hgt_m[id]);
		end
		r.top = HGT_W'(top_m);
		return r;
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [7:0] id,
			input logic signed [9:0] want);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.layer_id <= id;
		req.requested_height <= want;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_rsp.push_back(predict_stack(op, id, want));
		n_sent++;
	endtask

	// response checker
	always @(posedge clk) begin
		stack_rsp_t got;
		stack_rsp_t exp;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = {rsp.status, rsp.result_layer, rsp.final_height, rsp.top_height,
				rsp.refresh_needed};
			n_rsp++;
			if (pending_rsp.size() == 0) begin
				report("response with no request pending");
			end else begin
				exp = pending_rsp.pop_front();
				if (got.status !== exp.status)
					report($sformatf("status %0b exp %0b", got.status, exp.status));
				if (got.layer !== exp.layer)
					report($sformatf("layer %0d exp %0d", got.layer, exp.layer));
				if (got.fh !== exp.fh)
					report($sformatf("final height %0d exp %0d", got.fh, exp.fh));
				if (got.top !== exp.top)
					report($sformatf("top %0d exp %0d", got.top, exp.top));
				if (got.refresh !== exp.refresh)
					report($sformatf("refresh %0b exp %0b", got.refresh, exp.refresh));
			end
		end
	end

	always @(posedge clk) begin
		rsp.ready <= !hold_rsp && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("timeout");
			$display("[layer_z_order_manager_unit] ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] pick_used();
		int k;
		k = $urandom_range(255);
		for (int i = 0; i < 256; i++)
			if (used_m[(k + i) & 255]) return 8'((k + i) & 255);
		return 8'(k);
	endfunction

	function automatic logic signed [9:0] pick_height();
		case ($urandom_range(5))
			0: return -10'sd1;
			1: return 10'($urandom_range(1023));
			2: return 10'(top_m + 1);
			3: return 10'(top_m);
			default: return 10'($urandom_range(top_m + 2 > 0 ? top_m + 2 : 0));
		endcase
	endfunction

	task automatic test_directed();
		send_request(OP_SET, 8'd0, 10'sd0);
		send_request(OP_FREE, 8'd255, -10'sd1);
		send_request(OP_NOP, 8'd7, 10'sd3);
		for (int i = 0; i < 4; i++) send_request(OP_ALLOC, 8'd255, 10'sd0);
		send_request(OP_SET, 8'd0, 10'sd511);
		send_request(OP_SET, 8'd1, 10'sd511);
		send_request(OP_SET, 8'd2, 10'sd0);
		send_request(OP_SET, 8'd3, 10'sd1);
		send_request(OP_SET, 8'd3, 10'sd511);
		send_request(OP_SET, 8'd2, 10'sd2);
		send_request(OP_SET, 8'd2, 10'sd2);
		send_request(OP_SET, 8'd0, -10'sd512);
		send_request(OP_SET, 8'd1, -10'sd2);
		send_request(OP_FREE, 8'd3, 10'sd0);
		send_request(OP_FREE, 8'd3, 10'sd0);
		send_request(OP_ALLOC, 8'd0, 10'sd0);
		send_request(OP_FREE, 8'd2, 10'sd0);
	endtask

	task automatic test_full_stack();
		for (int i = 0; i < 257; i++) send_request(OP_ALLOC, 8'hAA, 10'sh155);
		for (int i = 0; i < 40; i++) send_request(OP_SET, pick_used(), 10'sd511);
		send_request(OP_SET, pick_used(), 10'sd0);
		for (int i = 0; i < 256; i++) send_request(OP_FREE, i[7:0], 10'sh2AA);
	endtask

	task automatic test_random(input int n);
		logic [1:0] op;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 15) op = OP_ALLOC;
			else if (r < 80) op = OP_SET;
			else if (r < 95) op = OP_FREE;
			else op = OP_NOP;
			send_request(op, ($urandom_range(9) == 0) ? 8'($urandom) : pick_used(),
				($urandom_range(9) == 0) ? 10'($urandom) : pick_height());
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_rsp = 1;
				repeat (300) @(posedge clk);
				hold_rsp = 0;
			end
			test_random(30);
		join
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_rsp.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	initial begin
		req.valid = 1'b0;
		req.opcode = OP_NOP;
		req.layer_id = '0;
		req.requested_height = '0;
		for (int i = 0; i < 256; i++) begin
			used_m[i] = 0;
			hgt_m[i] = -1;
			order_m[i] = '0;
		end
		top_m = -1;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_idle = 12;
		recv_idle = 75;
		test_directed();
		test_full_stack();
		test_random(300);
		send_idle = 75;
		recv_idle = 12;
		test_random(300);
		send_idle = 0;
		recv_idle = 0;
		test_backpressure();
		test_random(200);
		drain();
		$display("covered %0d requests, %0d responses: alloc to full, moves, hides, frees",
			n_sent, n_rsp);
		if (errors == 0) begin
			$display("[layer_z_order_manager_unit] OK");
		end else begin
			$display("[layer_z_order_manager_unit] ERROR");
		end
		$finish;
	end
endmodule
